>>> rtl/text_console_cursor_control_assert.svh
// Assertion macros for the text console cursor engine.
// Included by text_console_cursor_control, which carries concurrent checks; needs nothing else.
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TCC_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("text console cursor check failed");

// Check that cons holds in the cycle after ante.
`define TCC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("text console cursor check failed");

`endif

>>> rtl/tcc_pkg.sv
// Shared types and codes of the text console cursor engine.
// No dependencies; imported by text_console_cursor_control.
package tcc_pkg;

  // renderer command codes
  typedef enum logic [2:0] {
    OP_DRAW   = 3'd0,
    OP_SHIFT  = 3'd1,
    OP_SCROLL = 3'd2,
    OP_FILL   = 3'd3,
    OP_STATUS = 3'd4
  } op_t;

  // input word kinds
  localparam logic [1:0] KIND_PRINT  = 2'd0;
  localparam logic [1:0] KIND_LOCATE = 2'd1;
  localparam logic [1:0] KIND_ERASE  = 2'd2;

  // erase modes
  localparam logic [2:0] ERASE_SCR_FROM  = 3'd0;
  localparam logic [2:0] ERASE_SCR_TO    = 3'd1;
  localparam logic [2:0] ERASE_SCR_ALL   = 3'd2;
  localparam logic [2:0] ERASE_LINE_FROM = 3'd3;
  localparam logic [2:0] ERASE_LINE_TO   = 3'd4;
  localparam logic [2:0] ERASE_LINE_ALL  = 3'd5;

  // control characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // configuration register indexes
  localparam logic [2:0] CFG_COLUMNS     = 3'd0;
  localparam logic [2:0] CFG_ROWS        = 3'd1;
  localparam logic [2:0] CFG_WRAP        = 3'd2;
  localparam logic [2:0] CFG_FIRST_GLYPH = 3'd3;
  localparam logic [2:0] CFG_LAST_GLYPH  = 3'd4;

  // most space draws one tab may produce
  localparam logic [3:0] MAX_TAB_DRAWS = 4'd8;

  // one renderer command without glyph
  typedef struct packed {
    op_t        op;
    logic [7:0] c0;
    logic [7:0] r0;
    logic [8:0] c1;
    logic [8:0] r1;
  } rect_t;

  // everything needed to replay the words of one input item
  typedef struct packed {
    logic [3:0] n_draw;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] glyph;
    logic       has_a;
    rect_t      rect_a;
    rect_t      rect_b;
    logic [3:0] cnt;
    logic       ok;
  } job_t;

  function automatic rect_t mk_rect(op_t op, logic [7:0] c0, logic [7:0] r0,
                                    logic [8:0] c1, logic [8:0] r1);
    rect_t r;
    r.op = op;
    r.c0 = c0;
    r.r0 = r0;
    r.c1 = c1;
    r.r1 = r1;
    return r;
  endfunction

endpackage

>>> rtl/text_console_cursor_control.sv
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   kind, byte_in, target_col, target_row, erase_mode
// out_      output     out_valid / out_stall op, coordinates, glyph, cursor, locate_ok, last
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Cursor engine of a character-cell text console: top level.
// Depends on tcc_pkg and text_console_cursor_control_assert.svh.
//
// An item is decoded in the cycle it is accepted into the job register; the job
// then hands one word a cycle to the output register unless out_stall holds it,
// and an item yields 1 to 9 words (a tab run yields up to 9).
// in_stall is high while the job is busy, except in the cycle its last word moves out.
// Reset (rst_n low at a clock edge) loads the register defaults and homes the
// cursor; there is no clearing pass. out_stall holds the output register.
module text_console_cursor_control
  import tcc_pkg::*;
#(
  parameter int TAB_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // input items
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_byte_in,
  input  logic signed [8:0] in_target_col,
  input  logic signed [8:0] in_target_row,
  input  logic [2:0]        in_erase_mode,
  // renderer commands
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_op,
  output logic [7:0]        out_col_start,
  output logic [7:0]        out_row_start,
  output logic [8:0]        out_col_end,
  output logic [8:0]        out_row_end,
  output logic [7:0]        out_glyph_code,
  output logic [7:0]        out_cursor_col,
  output logic [7:0]        out_cursor_row,
  output logic              out_locate_ok,
  output logic              out_last,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  `include "text_console_cursor_control_assert.svh"

  // configuration and cursor state
  logic [7:0] cfg_columns_r, cfg_rows_r, cfg_first_r, cfg_last_r;
  logic       cfg_wrap_r;
  logic [7:0] cur_col_r, cur_row_r, cur_col_nxt, cur_row_nxt;

  // job register
  logic       job_vld_r, job_vld_nxt;
  logic [3:0] job_idx_r, job_idx_nxt;
  job_t       job_r, job_nxt;

  // output register
  logic       out_vld_r, out_vld_nxt;
  rect_t      out_rect_r;
  logic [7:0] out_glyph_r, out_ccol_r, out_crow_r;
  logic       out_ok_r, out_last_r;

  // handshake
  logic accept, out_load, emit, emit_last;

  // tab length for each cursor column
  logic [4:0] tab_len_tbl [256];
  for (genvar i = 0; i < 256; i++) begin : g_tab
    assign tab_len_tbl[i] = 5'(TAB_WIDTH - (i % TAB_WIDTH));
  end

  // handshake glue
  assign cfg_ready = 1'b1;
  assign out_load  = !out_vld_r || !out_stall;
  assign emit      = job_vld_r && out_load;
  assign emit_last = emit && (job_idx_r == job_r.cnt - 4'd1);
  assign in_stall  = job_vld_r && !emit_last;
  assign accept    = in_valid && !in_stall;

  // decode one item into a job and the next cursor
  always_comb begin
    logic [7:0] last_col, last_row, x, y, room, n_room, glyph;
    logic [8:0] x_inc, y_inc, cols9, rows9, tab_end;
    logic [4:0] len;
    logic       nl_bottom, nl_scroll;
    logic [7:0] nl_row;
    rect_t      scroll_rect, status_rect;
    logic       has_b;

    x = cur_col_r;
    y = cur_row_r;
    cols9 = {1'b0, cfg_columns_r};
    rows9 = {1'b0, cfg_rows_r};
    x_inc = {1'b0, x} + 9'd1;
    y_inc = {1'b0, y} + 9'd1;
    last_col = (cfg_columns_r == 8'd0) ? 8'd0 : cfg_columns_r - 8'd1;
    last_row = (cfg_rows_r == 8'd0) ? 8'd0 : cfg_rows_r - 8'd1;
    nl_bottom = (y >= last_row);
    nl_scroll = nl_bottom && (cfg_rows_r >= 8'd2);
    nl_row = nl_bottom ? last_row : y_inc[7:0];
    scroll_rect = mk_rect(OP_SCROLL, 8'd0, 8'd0, cols9, rows9);
    status_rect = mk_rect(OP_STATUS, 8'd0, 8'd0, 9'd0, 9'd0);

    len = tab_len_tbl[x];
    room = (x < cfg_columns_r) ? cfg_columns_r - x : 8'd0;
    n_room = (room < {3'b0, len}) ? room : {3'b0, len};
    tab_end = {1'b0, x} + {4'b0, len};
    glyph = in_byte_in;
    if (in_byte_in <= CH_SPACE || !(in_byte_in inside {[cfg_first_r:cfg_last_r]})) begin
      glyph = CH_SPACE;
    end

    has_b = 1'b0;
    job_nxt.n_draw = 4'd0;
    job_nxt.x = x;
    job_nxt.y = y;
    job_nxt.glyph = CH_SPACE;
    job_nxt.has_a = 1'b0;
    job_nxt.rect_a = status_rect;
    job_nxt.rect_b = status_rect;
    job_nxt.ok = 1'b0;
    cur_col_nxt = x;
    cur_row_nxt = y;

    case (in_kind)
      KIND_PRINT: begin
        case (in_byte_in)
          CH_BS: begin
            if (x != 8'd0) begin
              job_nxt.has_a = 1'b1;
              job_nxt.rect_a = mk_rect(OP_SHIFT, x, y, cols9, y_inc);
              has_b = 1'b1;
              job_nxt.rect_b = mk_rect(OP_FILL, last_col, y, cols9, y_inc);
              cur_col_nxt = x - 8'd1;
            end
          end
          CH_TAB: begin
            job_nxt.n_draw = (n_room > {4'b0, MAX_TAB_DRAWS}) ? MAX_TAB_DRAWS : n_room[3:0];
            if (tab_end >= cols9) begin
              cur_col_nxt = last_col;
              if (cfg_wrap_r) begin
                job_nxt.has_a = nl_scroll;
                job_nxt.rect_a = scroll_rect;
                cur_col_nxt = 8'd0;
                cur_row_nxt = nl_row;
              end
            end else begin
              cur_col_nxt = tab_end[7:0];
            end
          end
          CH_LF: begin
            job_nxt.has_a = nl_scroll;
            job_nxt.rect_a = scroll_rect;
            cur_col_nxt = 8'd0;
            cur_row_nxt = nl_row;
          end
          CH_CR, CH_DEL: begin
          end
          default: begin
            job_nxt.n_draw = 4'd1;
            job_nxt.glyph = glyph;
            if (x >= last_col) begin
              if (cfg_wrap_r) begin
                job_nxt.has_a = nl_scroll;
                job_nxt.rect_a = scroll_rect;
                cur_col_nxt = 8'd0;
                cur_row_nxt = nl_row;
              end
            end else begin
              cur_col_nxt = x_inc[7:0];
            end
          end
        endcase
      end
      KIND_LOCATE: begin
        if (!in_target_col[8] && !in_target_row[8] &&
            in_target_col[7:0] < cfg_columns_r && in_target_row[7:0] < cfg_rows_r) begin
          job_nxt.ok = 1'b1;
          cur_col_nxt = in_target_col[7:0];
          cur_row_nxt = in_target_row[7:0];
        end
      end
      KIND_ERASE: begin
        case (in_erase_mode)
          ERASE_SCR_FROM: begin
            job_nxt.has_a = 1'b1;
            job_nxt.rect_a = mk_rect(OP_FILL, x, y, cols9, y_inc);
            has_b = (y_inc < rows9);
            job_nxt.rect_b = mk_rect(OP_FILL, 8'd0, y_inc[7:0], cols9, rows9);
          end
          ERASE_SCR_TO: begin
            job_nxt.has_a = 1'b1;
            if (y != 8'd0) begin
              job_nxt.rect_a = mk_rect(OP_FILL, 8'd0, 8'd0, cols9, {1'b0, y});
              has_b = 1'b1;
              job_nxt.rect_b = mk_rect(OP_FILL, 8'd0, y, x_inc, y_inc);
            end else begin
              job_nxt.rect_a = mk_rect(OP_FILL, 8'd0, y, x_inc, y_inc);
            end
          end
          ERASE_SCR_ALL: begin
            job_nxt.has_a = 1'b1;
            job_nxt.rect_a = mk_rect(OP_FILL, 8'd0, 8'd0, cols9, rows9);
          end
          ERASE_LINE_FROM: begin
            job_nxt.has_a = 1'b1;
            job_nxt.rect_a = mk_rect(OP_FILL, x, y, cols9, y_inc);
          end
          ERASE_LINE_TO: begin
            job_nxt.has_a = 1'b1;
            job_nxt.rect_a = mk_rect(OP_FILL, 8'd0, y, x_inc, y_inc);
          end
          ERASE_LINE_ALL: begin
            job_nxt.has_a = 1'b1;
            job_nxt.rect_a = mk_rect(OP_FILL, 8'd0, y, cols9, y_inc);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    // an item with nothing to render still reports the cursor
    if (job_nxt.n_draw == 4'd0 && !job_nxt.has_a && !has_b) begin
      job_nxt.has_a = 1'b1;
      job_nxt.rect_a = status_rect;
    end
    job_nxt.cnt = job_nxt.n_draw + {3'b0, job_nxt.has_a} + {3'b0, has_b};
  end

  // advance the job and the output register
  always_comb begin
    job_vld_nxt = job_vld_r;
    job_idx_nxt = job_idx_r;
    out_vld_nxt = out_vld_r;
    if (emit) begin
      job_idx_nxt = job_idx_r + 4'd1;
    end
    if (emit_last) begin
      job_vld_nxt = 1'b0;
    end
    if (accept) begin
      job_vld_nxt = 1'b1;
      job_idx_nxt = 4'd0;
    end
    if (out_load) begin
      out_vld_nxt = emit;
    end
  end

  // select the word at the current job index
  rect_t      word_rect;
  logic [7:0] word_glyph;
  always_comb begin
    word_glyph = 8'd0;
    if (job_idx_r < job_r.n_draw) begin
      word_rect = mk_rect(OP_DRAW, job_r.x + {4'b0, job_idx_r}, job_r.y, 9'd0, 9'd0);
      word_glyph = job_r.glyph;
    end else if (job_idx_r == job_r.n_draw && job_r.has_a) begin
      word_rect = job_r.rect_a;
    end else begin
      word_rect = job_r.rect_b;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_columns_r <= 8'd80;
      cfg_rows_r    <= 8'd25;
      cfg_wrap_r    <= 1'b1;
      cfg_first_r   <= 8'd32;
      cfg_last_r    <= 8'd126;
      cur_col_r     <= 8'd0;
      cur_row_r     <= 8'd0;
      job_vld_r     <= 1'b0;
      job_idx_r     <= 4'd0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COLUMNS:     cfg_columns_r <= cfg_data;
          CFG_ROWS:        cfg_rows_r    <= cfg_data;
          CFG_WRAP:        cfg_wrap_r    <= cfg_data[0];
          CFG_FIRST_GLYPH: cfg_first_r   <= cfg_data;
          CFG_LAST_GLYPH:  cfg_last_r    <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
      end
      job_vld_r <= job_vld_nxt;
      job_idx_r <= job_idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
    if (emit) begin
      out_rect_r  <= word_rect;
      out_glyph_r <= word_glyph;
      out_ccol_r  <= cur_col_r;
      out_crow_r  <= cur_row_r;
      out_ok_r    <= job_r.ok;
      out_last_r  <= (job_idx_r == job_r.cnt - 4'd1);
    end
  end

  assign out_valid      = out_vld_r;
  assign out_op         = out_rect_r.op;
  assign out_col_start  = out_rect_r.c0;
  assign out_row_start  = out_rect_r.r0;
  assign out_col_end    = out_rect_r.c1;
  assign out_row_end    = out_rect_r.r1;
  assign out_glyph_code = out_glyph_r;
  assign out_cursor_col = out_ccol_r;
  assign out_cursor_row = out_crow_r;
  assign out_locate_ok  = out_ok_r;
  assign out_last       = out_last_r;

  // checks
  `TCC_ASSERT_NOW(a_idx_in_range, clk, rst_n, job_vld_r, job_idx_r < job_r.cnt)
  `TCC_ASSERT_NEXT(a_idx_step, clk, rst_n, emit && !emit_last, job_vld_r && job_idx_r == $past(job_idx_r) + 4'd1)
  `TCC_ASSERT_NOW(a_locate_single, clk, rst_n, job_vld_r && job_r.ok, job_r.cnt == 4'd1)
  `TCC_ASSERT_NOW(a_tab_draw_cap, clk, rst_n, job_vld_r, job_r.n_draw <= MAX_TAB_DRAWS)

endmodule
